// File: hdl/knock_feature_extractor_assert.svh
// Assertion macros shared by the knock feature extractor RTL.
// No dependencies; define ASSERT_OFF to compile the checks away.
`ifndef KNOCK_FEATURE_EXTRACTOR_ASSERT_SVH
`define KNOCK_FEATURE_EXTRACTOR_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, ignored while reset is asserted.
`define KFE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("knock feature extractor assertion failed");
// Next-cycle implication, ignored while reset is asserted.
`define KFE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("knock feature extractor assertion failed");
`else
`define KFE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define KFE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/kfe_pkg.sv
// Shared types and constants of the knock feature extractor.
// No dependencies; imported by the controller, datapath and top level.
package kfe_pkg;

    localparam int REV_W     = 16;
    localparam int HEALTH_W  = 3;
    localparam int QUALITY_W = 2;
    localparam int FAULTS_W  = 16;
    localparam int DROP_W    = 16;
    localparam int CAP_W     = 5;
    localparam int FRAC_BITS = 16;
    localparam int NORM_FRAC = 8;
    localparam int QUO_BITS  = 16;
    localparam int STEP_W    = $clog2(QUO_BITS);
    localparam int CFG_IDX_W = 1;

    // 0.95 and 0.05 in Q0.16.
    localparam logic [15:0] KEEP_WEIGHT = 16'd62259;
    localparam logic [11:0] NEW_WEIGHT  = 12'd3277;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_CAPACITY     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND_DEFAULT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_DIV_INIT,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept_submit;
        logic accept_extract;
        logic mul;
        logic upd;
        logic div_init;
        logic div_step;
        logic load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic empty;
        logic div_skip;
        logic div_last;
        logic out_free;
    } t_ctrl_sts;

endpackage

// File: hdl/kfe_ctrl.sv
// Sequencer of the knock feature extractor: accepts words and steps the datapath.
// Depends on kfe_pkg and the assertion macro header.
`include "knock_feature_extractor_assert.svh"

module kfe_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_kind,
    input  kfe_pkg::t_ctrl_sts i_sts,
    output logic               o_in_ready,
    output kfe_pkg::t_ctrl_cmd o_cmd
);
    import kfe_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (!i_kind) begin
                        o_cmd.accept_submit = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        o_cmd.accept_extract = 1'b1;
                        n_state = i_sts.empty ? S_DONE : S_MUL;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_DIV_INIT;
            end
            S_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_state = i_sts.div_skip ? S_DONE : S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `KFE_ASSERT_NXT(a_idle_holds, i_clk, i_rst_n, (r_state == S_IDLE) && !i_in_valid, r_state == S_IDLE)
    `KFE_ASSERT_NXT(a_div_ends, i_clk, i_rst_n, (r_state == S_DIV) && i_sts.div_last, r_state == S_DONE)
    `KFE_ASSERT_NXT(a_done_waits, i_clk, i_rst_n, (r_state == S_DONE) && !i_sts.out_free, r_state == S_DONE)

endmodule

// File: hdl/kfe_dp.sv
// Datapath of the knock feature extractor: measurement queue, background
// average, serial divider and result register. Depends on kfe_pkg and the macros.
`include "knock_feature_extractor_assert.svh"

module kfe_dp #(
    parameter int QUEUE_DEPTH = 16,
    parameter int COUNT_BITS  = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  kfe_pkg::t_ctrl_cmd            i_cmd,
    output kfe_pkg::t_ctrl_sts            o_sts,
    input  logic                          i_cfg_we,
    input  logic [kfe_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COUNT_BITS-1:0]         i_cfg_data,
    input  logic [kfe_pkg::REV_W-1:0]     i_rev_id_in,
    input  logic [COUNT_BITS-1:0]         i_raw_count,
    input  logic                          i_usable,
    input  logic [kfe_pkg::HEALTH_W-1:0]  i_health_in,
    input  logic [kfe_pkg::QUALITY_W-1:0] i_quality_in,
    input  logic [kfe_pkg::FAULTS_W-1:0]  i_faults_in,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic                          o_accepted,
    output logic                          o_record_valid,
    output logic [kfe_pkg::REV_W-1:0]     o_rev_id_out,
    output logic [kfe_pkg::QUO_BITS-1:0]  o_norm_index,
    output logic                          o_knock_flag,
    output logic [kfe_pkg::HEALTH_W-1:0]  o_health_out,
    output logic [kfe_pkg::QUALITY_W-1:0] o_quality_out,
    output logic [kfe_pkg::FAULTS_W-1:0]  o_faults_out,
    output logic [kfe_pkg::DROP_W-1:0]    o_drop_total
);
    import kfe_pkg::*;

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int ENT_W  = REV_W + COUNT_BITS + 1 + HEALTH_W + QUALITY_W + FAULTS_W;
    localparam int BG_W   = COUNT_BITS + FRAC_BITS;
    localparam int KEEP_W = BG_W + 16;
    localparam int NEW_W  = COUNT_BITS + 12;

    // Queue storage and pointers.
    logic [ENT_W-1:0] r_mem [QUEUE_DEPTH];
    logic [ENT_W-1:0] r_rd;
    logic [PTR_W-1:0] r_head;
    logic [PTR_W-1:0] r_tail;
    logic [CNT_W-1:0] r_count;

    logic [CAP_W-1:0]      r_capacity;
    logic [BG_W-1:0]       r_bg;
    logic [DROP_W-1:0]     r_drop;

    logic                  r_stored;
    logic                  r_hit;
    logic [KEEP_W-1:0]     r_prod_keep;
    logic [NEW_W-1:0]      r_prod_new;
    logic [BG_W-1:0]       r_rem;
    logic [QUO_BITS-1:0]   r_quo;
    logic [STEP_W-1:0]     r_step;
    logic                  r_knock;

    logic [REV_W-1:0]      rd_rev;
    logic [COUNT_BITS-1:0] rd_raw;
    logic                  rd_ok;
    logic [HEALTH_W-1:0]   rd_health;
    logic [QUALITY_W-1:0]  rd_quality;
    logic [FAULTS_W-1:0]   rd_faults;

    logic [CMP_W-1:0] cap_eff;
    logic             can_store;
    logic             empty;
    logic [BG_W-1:0]  raw_scaled;
    logic             bg_zero;
    logic             quo_sat;
    logic             raw_above;
    logic [BG_W:0]    rem_shift;
    logic [BG_W:0]    rem_diff;
    logic [BG_W:0]    bg_sum;
    logic             out_free;
    logic             r_out_valid;

    assign {rd_rev, rd_raw, rd_ok, rd_health, rd_quality, rd_faults} = r_rd;

    always_comb begin
        if (CMP_W'(r_capacity) > CMP_W'(QUEUE_DEPTH)) begin
            cap_eff = CMP_W'(QUEUE_DEPTH);
        end else begin
            cap_eff = CMP_W'(r_capacity);
        end
    end

    assign can_store  = CMP_W'(r_count) < cap_eff;
    assign empty      = (r_count == '0);
    // raw scaled by 2^8 is the top of the dividend raw * 2^24.
    assign raw_scaled = BG_W'({rd_raw, {NORM_FRAC{1'b0}}});
    assign bg_zero    = (r_bg == '0);
    // The quotient overflows 16 bits exactly when raw * 2^8 reaches the background.
    assign quo_sat    = (raw_scaled >= r_bg);
    assign raw_above  = {1'b0, rd_raw, {FRAC_BITS{1'b0}}} > {r_bg, 1'b0};
    assign rem_shift  = {r_rem, 1'b0};
    assign rem_diff   = rem_shift - {1'b0, r_bg};
    assign bg_sum     = {1'b0, r_prod_keep[KEEP_W-1:FRAC_BITS]}
                      + (BG_W + 1)'(r_prod_new);
    assign out_free   = !r_out_valid || i_out_ready;

    assign o_sts.empty    = empty;
    assign o_sts.div_skip = bg_zero || quo_sat;
    assign o_sts.div_last = (r_step == STEP_W'(QUO_BITS - 1));
    assign o_sts.out_free = out_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_submit && can_store) begin
            r_mem[r_tail] <= {i_rev_id_in, i_raw_count, i_usable,
                              i_health_in, i_quality_in, i_faults_in};
        end
        if (i_cmd.accept_extract) begin
            r_rd <= r_mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= '0;
            r_tail       <= '0;
            r_count      <= '0;
            r_drop       <= '0;
            r_capacity   <= CAP_W'(16);
            r_bg         <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.accept_submit) begin
                if (can_store) begin
                    r_tail  <= (r_tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;
                    r_count <= r_count + 1'b1;
                end else begin
                    r_drop <= r_drop + 1'b1;
                end
            end
            if (i_cmd.accept_extract && !empty) begin
                r_head  <= (r_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                r_count <= r_count - 1'b1;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_QUEUE_CAPACITY: begin
                        r_capacity <= i_cfg_data[CAP_W-1:0];
                    end
                    CFG_BACKGROUND_DEFAULT: begin
                        r_bg <= {i_cfg_data, {FRAC_BITS{1'b0}}};
                    end
                    default: begin
                    end
                endcase
            end else if (i_cmd.upd && rd_ok) begin
                r_bg <= bg_sum[BG_W-1:0];
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Arithmetic and result registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_submit || i_cmd.accept_extract) begin
            r_stored <= i_cmd.accept_submit && can_store;
            r_hit    <= i_cmd.accept_extract && !empty;
            r_quo    <= '0;
            r_knock  <= 1'b0;
        end
        if (i_cmd.mul) begin
            r_prod_keep <= {16'b0, r_bg} * {{BG_W{1'b0}}, KEEP_WEIGHT};
            r_prod_new  <= {12'b0, rd_raw} * {{COUNT_BITS{1'b0}}, NEW_WEIGHT};
        end
        if (i_cmd.div_init) begin
            r_rem   <= raw_scaled;
            r_step  <= '0;
            r_quo   <= (!bg_zero && quo_sat) ? '1 : '0;
            r_knock <= rd_ok && !bg_zero && raw_above;
        end
        if (i_cmd.div_step) begin
            r_step <= r_step + 1'b1;
            if (!rem_diff[BG_W]) begin
                r_rem <= rem_diff[BG_W-1:0];
                r_quo <= {r_quo[QUO_BITS-2:0], 1'b1};
            end else begin
                r_rem <= rem_shift[BG_W-1:0];
                r_quo <= {r_quo[QUO_BITS-2:0], 1'b0};
            end
        end
        if (i_cmd.load_out) begin
            o_accepted     <= r_stored;
            o_record_valid <= r_hit;
            o_rev_id_out   <= r_hit ? rd_rev : '0;
            o_norm_index   <= r_quo;
            o_knock_flag   <= r_knock;
            o_health_out   <= r_hit ? rd_health : '0;
            o_quality_out  <= r_hit ? rd_quality : '0;
            o_faults_out   <= r_hit ? rd_faults : '0;
            o_drop_total   <= r_drop;
        end
    end

    assign o_out_valid = r_out_valid;

    `KFE_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(QUEUE_DEPTH))
    `KFE_ASSERT_NXT(a_pop_count, i_clk, i_rst_n, i_cmd.accept_extract && !empty, r_count == $past(r_count) - 1'b1)
    `KFE_ASSERT_NXT(a_drop_count, i_clk, i_rst_n, i_cmd.accept_submit && !can_store, (r_drop == $past(r_drop) + 1'b1) && (r_count == $past(r_count)))

endmodule

// File: hdl/knock_feature_extractor.sv
// Top level of the knock feature extractor: sequencer plus datapath.
// Depends on kfe_pkg, kfe_ctrl and kfe_dp.
//
//  Channel   Handshake                   Payload
//  input     i_in_valid / o_in_ready     kind, revolution, raw count, usable, codes
//  output    o_out_valid / i_out_ready   flags, revolution, index, codes, drop total
//  config    i_cfg_we (no wait)          i_cfg_idx, i_cfg_data
//
// A submit word, or an extract from an empty queue, goes straight to the done
// state; an extract that pops an entry first runs multiply, add and the 16-step
// restoring divider, whose steps a zero background or a saturating quotient
// skips. One word is in work at a time; the next is taken while a result waits
// to go out, and is held in the done state until the output register is free.
// Reset is synchronous and active low; the queue is empty and background zero.
module knock_feature_extractor #(
    parameter int QUEUE_DEPTH = 16,
    parameter int COUNT_BITS  = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_kind,
    input  logic [kfe_pkg::REV_W-1:0]     i_rev_id_in,
    input  logic [COUNT_BITS-1:0]         i_raw_count,
    input  logic                          i_usable,
    input  logic [kfe_pkg::HEALTH_W-1:0]  i_health_in,
    input  logic [kfe_pkg::QUALITY_W-1:0] i_quality_in,
    input  logic [kfe_pkg::FAULTS_W-1:0]  i_faults_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_accepted,
    output logic                          o_record_valid,
    output logic [kfe_pkg::REV_W-1:0]     o_rev_id_out,
    output logic [kfe_pkg::QUO_BITS-1:0]  o_norm_index,
    output logic                          o_knock_flag,
    output logic [kfe_pkg::HEALTH_W-1:0]  o_health_out,
    output logic [kfe_pkg::QUALITY_W-1:0] o_quality_out,
    output logic [kfe_pkg::FAULTS_W-1:0]  o_faults_out,
    output logic [kfe_pkg::DROP_W-1:0]    o_drop_total,
    input  logic                          i_cfg_we,
    input  logic [kfe_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COUNT_BITS-1:0]         i_cfg_data
);
    import kfe_pkg::*;

    t_ctrl_cmd cmd;
    t_ctrl_sts sts;

    kfe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    kfe_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_rev_id_in    (i_rev_id_in),
        .i_raw_count    (i_raw_count),
        .i_usable       (i_usable),
        .i_health_in    (i_health_in),
        .i_quality_in   (i_quality_in),
        .i_faults_in    (i_faults_in),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_accepted     (o_accepted),
        .o_record_valid (o_record_valid),
        .o_rev_id_out   (o_rev_id_out),
        .o_norm_index   (o_norm_index),
        .o_knock_flag   (o_knock_flag),
        .o_health_out   (o_health_out),
        .o_quality_out  (o_quality_out),
        .o_faults_out   (o_faults_out),
        .o_drop_total   (o_drop_total)
    );

endmodule
